// ----- rtl/ofdm_dmap_pkg.sv -----
// Shared types, constants and demapping tables for the OFDM soft demapper.
package ofdm_dmap_pkg;

  localparam int unsigned FFT_POINTS    = 64;
  localparam int unsigned DATA_CARRIERS = 48;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned QSAMPLE_W     = 8;
  localparam int unsigned WEIGHT_W      = 8;
  localparam int unsigned SOFT_W        = 8;
  localparam int unsigned NUM_SOFT      = 6;
  localparam int unsigned NBITS_W       = 3;
  localparam int unsigned CARRIER_W     = 6;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 64;
  localparam int unsigned QUANT_SCALE   = 100;
  localparam int unsigned QUANT_SHIFT   = 12;
  localparam int signed   QSAT_HI       = 127;
  localparam int signed   QSAT_LO       = -128;
  localparam logic [CARRIER_W-1:0] LAST_CARRIER = CARRIER_W'(26);

  typedef enum logic [1:0] {
    ModBpsk  = 2'd0,
    ModQpsk  = 2'd1,
    ModQam16 = 2'd2,
    ModQam64 = 2'd3
  } mod_e;

  localparam logic [NBITS_W-1:0] NBITS_BPSK  = NBITS_W'(1);
  localparam logic [NBITS_W-1:0] NBITS_QPSK  = NBITS_W'(2);
  localparam logic [NBITS_W-1:0] NBITS_QAM16 = NBITS_W'(4);
  localparam logic [NBITS_W-1:0] NBITS_QAM64 = NBITS_W'(6);

  typedef struct packed {
    logic [QSAMPLE_W-1:0] re;
    logic [QSAMPLE_W-1:0] im;
    logic [WEIGHT_W-1:0]  weight;
  } carrier_entry_t;

  typedef logic [NUM_SOFT-1:0][SOFT_W-1:0] soft_vec_t;

  // Clamp a small signed value to 0..7.
  function automatic logic [2:0] clamp07(input logic signed [9:0] v);
    logic [2:0] r;
    if (v < 10'sd0) begin
      r = 3'd0;
    end else if (v > 10'sd7) begin
      r = 3'd7;
    end else begin
      r = v[2:0];
    end
    return r;
  endfunction

  // Magnitude fold: s for s >= 0, -s-1 otherwise.
  function automatic logic [6:0] fold(input logic [QSAMPLE_W-1:0] idx);
    return idx[7] ? ~idx[6:0] : idx[6:0];
  endfunction

  function automatic logic [2:0] rom_sign(input logic [QSAMPLE_W-1:0] idx);
    return clamp07({{2{idx[7]}}, idx} + 10'sd4);
  endfunction

  function automatic logic [2:0] rom_qam16_level(input logic [QSAMPLE_W-1:0] idx);
    return clamp07(10'sd66 - $signed({3'b000, fold(idx)}));
  endfunction

  function automatic logic [2:0] rom_qam64_level2(input logic [QSAMPLE_W-1:0] idx);
    return clamp07(10'sd65 - $signed({3'b000, fold(idx)}));
  endfunction

  function automatic logic [2:0] rom_qam64_level3(input logic [QSAMPLE_W-1:0] idx);
    logic signed [9:0] m;
    logic signed [9:0] up;
    logic signed [9:0] down;
    m    = $signed({3'b000, fold(idx)});
    up   = m - 10'sd27;
    down = 10'sd95 - m;
    return clamp07((up < down) ? up : down);
  endfunction

  // Emit position to FFT index: 38..63 then 1..26, pilots skipped.
  function automatic logic [CARRIER_W-1:0] data_carrier(input logic [POS_W-1:0] pos);
    logic [CARRIER_W-1:0] c;
    case (pos) inside
      [6'd0:6'd4]:   c = pos + CARRIER_W'(38);
      [6'd5:6'd17]:  c = pos + CARRIER_W'(39);
      [6'd18:6'd23]: c = pos + CARRIER_W'(40);
      [6'd24:6'd29]: c = pos - CARRIER_W'(23);
      [6'd30:6'd42]: c = pos - CARRIER_W'(22);
      [6'd43:6'd47]: c = pos - CARRIER_W'(21);
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ofdm_dmap_calc.sv -----
// Soft-bit computation for one stored carrier entry.
module ofdm_dmap_calc
  import ofdm_dmap_pkg::*;
(
  input  carrier_entry_t       entry_i,
  input  mod_e                 modulation_i,
  output soft_vec_t            soft_o,
  output logic [NBITS_W-1:0]   nbits_o
);

  // (min(255, floor(w*t/32) + 1)) >> 1
  function automatic logic [SOFT_W-1:0] weigh(input logic [WEIGHT_W-1:0] w,
                                               input logic [2:0] t);
    logic [WEIGHT_W+2:0] prod;
    logic [WEIGHT_W:0]   v;
    prod = (WEIGHT_W+3)'(w) * (WEIGHT_W+3)'(t);
    v    = {3'b000, prod[WEIGHT_W+2:5]} + (WEIGHT_W+1)'(1);
    if (v > (WEIGHT_W+1)'(255)) begin
      v = (WEIGHT_W+1)'(255);
    end
    return v[SOFT_W:1];
  endfunction

  logic [2:0] sign_re, sign_im, lv16_re, lv16_im;
  logic [2:0] lv2_re, lv2_im, lv3_re, lv3_im;

  assign sign_re = rom_sign(entry_i.re);
  assign sign_im = rom_sign(entry_i.im);
  assign lv16_re = rom_qam16_level(entry_i.re);
  assign lv16_im = rom_qam16_level(entry_i.im);
  assign lv2_re  = rom_qam64_level2(entry_i.re);
  assign lv2_im  = rom_qam64_level2(entry_i.im);
  assign lv3_re  = rom_qam64_level3(entry_i.re);
  assign lv3_im  = rom_qam64_level3(entry_i.im);

  always_comb begin
    soft_o = '0;
    case (modulation_i)
      ModBpsk: begin
        soft_o[0] = SOFT_W'(sign_re);
        nbits_o   = NBITS_BPSK;
      end
      ModQpsk: begin
        soft_o[0] = SOFT_W'(sign_re);
        soft_o[1] = SOFT_W'(sign_im);
        nbits_o   = NBITS_QPSK;
      end
      ModQam16: begin
        soft_o[0] = SOFT_W'(sign_re);
        soft_o[1] = SOFT_W'(lv16_re);
        soft_o[2] = SOFT_W'(sign_im);
        soft_o[3] = SOFT_W'(lv16_im);
        nbits_o   = NBITS_QAM16;
      end
      default: begin
        soft_o[0] = weigh(entry_i.weight, sign_re);
        soft_o[1] = weigh(entry_i.weight, lv2_re);
        soft_o[2] = weigh(entry_i.weight, lv3_re);
        soft_o[3] = weigh(entry_i.weight, sign_im);
        soft_o[4] = weigh(entry_i.weight, lv2_im);
        soft_o[5] = weigh(entry_i.weight, lv3_im);
        nbits_o   = NBITS_QAM64;
      end
    endcase
  end

endmodule

// ----- rtl/ofdm_soft_demapper.sv -----
// Top level of the OFDM soft demapper: carrier store, load and emit sequencer.
//
// Usage:
//   The slave stream takes one subcarrier per request in FFT order 0..63.
//   Each sample part is scaled by 100/4096 toward zero, saturated to 8 bits
//   and written with its weight into a 64-entry synchronous carrier store.
//   After the 64th request the block stops taking input and reads the 48
//   data carriers (38..63, then 1..26, pilots skipped) out of the store, one
//   read per cycle unless stalled; each read entry is demapped into up to six
//   soft bits and presented on the master stream, tlast marking carrier 26.
//   Timing: the single store read port gives one entry a cycle while the
//   receiver keeps up. The 64th request sets the phase register; the first
//   read then passes the store read register and the output register to the
//   master stream. The input reopens in the cycle after the last store read
//   is issued.
//   Stalls: a low m_axis_tready holds the output register and the read stage
//   behind it, and the sequencer issues no further reads until space frees.
//   Reset clears the phase, load counter, emit position, pipeline valids
//   and the modulation register (BPSK); the store contents are not cleared.
//   Write the modulation register only while the block is idle.
module ofdm_soft_demapper
  import ofdm_dmap_pkg::*;
#(
  parameter int unsigned FftPoints = FFT_POINTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_wdata_i,     // modulation
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sample_re[15:0], sample_im[31:16], weight[39:32]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // soft_0[7:0] .. soft_5[47:40], bits_valid[50:48], carrier[56:51], zero[63:57]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast     // last
);

  localparam int unsigned AddrW = $clog2(FftPoints);

  typedef enum logic {
    PhLoad,
    PhEmit
  } phase_e;

  // Sequencer state
  phase_e               phase_q, phase_d;
  logic [AddrW-1:0]     load_cnt_q, load_cnt_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 rd_valid_q, rd_valid_d;
  logic                 out_valid_q, out_valid_d;
  mod_e                 mod_q;

  // Payload registers
  carrier_entry_t       mem_q [FftPoints];
  carrier_entry_t       rdata_q;
  logic [CARRIER_W-1:0] rd_carrier_q;
  logic                 rd_last_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                 out_last_q;

  logic                 load_fire;
  logic                 issue;
  logic                 advance;
  logic [CARRIER_W-1:0] rd_carrier;
  carrier_entry_t       wr_entry;
  soft_vec_t            soft_bits;
  logic [NBITS_W-1:0]   nbits;

  // Scale by 100/4096 with truncation toward zero, then saturate to 8 bits.
  function automatic logic [QSAMPLE_W-1:0] quantize(input logic [SAMPLE_W-1:0] raw);
    logic signed [SAMPLE_W+7:0] prod;
    logic signed [SAMPLE_W+7:0] biased;
    logic signed [SAMPLE_W-5:0] q;
    logic [QSAMPLE_W-1:0]       r;
    prod   = $signed({{8{raw[SAMPLE_W-1]}}, raw}) * (SAMPLE_W+8)'(QUANT_SCALE);
    biased = prod[SAMPLE_W+7] ? prod + (SAMPLE_W+8)'((1 << QUANT_SHIFT) - 1) : prod;
    q      = biased[SAMPLE_W+7:QUANT_SHIFT];
    if (q > (SAMPLE_W-4)'(QSAT_HI)) begin
      r = QSAMPLE_W'(QSAT_HI);
    end else if (q < $signed((SAMPLE_W-4)'(QSAT_LO))) begin
      r = QSAMPLE_W'(QSAT_LO);
    end else begin
      r = q[QSAMPLE_W-1:0];
    end
    return r;
  endfunction

  assign s_axis_tready = (phase_q == PhLoad);
  assign load_fire     = s_axis_tvalid && s_axis_tready;

  // Move the read stage into the output register when it is empty or drains.
  assign advance = rd_valid_q && (!out_valid_q || m_axis_tready);
  // Issue the next store read when the read stage is free or moving on.
  assign issue   = (phase_q == PhEmit) && (!rd_valid_q || advance);

  assign rd_carrier = data_carrier(pos_q);

  assign wr_entry.re     = quantize(s_axis_tdata[SAMPLE_W-1:0]);
  assign wr_entry.im     = quantize(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
  assign wr_entry.weight = s_axis_tdata[2*SAMPLE_W+WEIGHT_W-1:2*SAMPLE_W];

  always_comb begin
    phase_d     = phase_q;
    load_cnt_d  = load_cnt_q;
    pos_d       = pos_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q;

    if (load_fire) begin
      load_cnt_d = load_cnt_q + AddrW'(1);
      if (load_cnt_q == AddrW'(FftPoints - 1)) begin
        phase_d = PhEmit;
      end
    end

    if (issue) begin
      rd_valid_d = 1'b1;
      if (pos_q == POS_W'(DATA_CARRIERS - 1)) begin
        pos_d   = '0;
        phase_d = PhLoad;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end else if (advance) begin
      rd_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLoad;
      load_cnt_q  <= '0;
      pos_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= ModBpsk;
    end else begin
      phase_q     <= phase_d;
      load_cnt_q  <= load_cnt_d;
      pos_q       <= pos_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mod_q <= mod_e'(cfg_wdata_i);
      end
    end
  end

  // Carrier store: one write port for loads, one registered read port for emits.
  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      mem_q[load_cnt_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q      <= mem_q[rd_carrier[AddrW-1:0]];
      rd_carrier_q <= rd_carrier;
      rd_last_q    <= (pos_q == POS_W'(DATA_CARRIERS - 1));
    end
  end

  ofdm_dmap_calc u_calc (
    .entry_i      (rdata_q),
    .modulation_i (mod_q),
    .soft_o       (soft_bits),
    .nbits_o      (nbits)
  );

  // Output register; hold while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_TDATA_W'({rd_carrier_q, nbits, soft_bits});
      out_last_q <= rd_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // No store read while the input side is open.
  a_no_read_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !s_axis_tready)
    else $error("store read issued during load phase");

  // The symbol ends on carrier 26.
  a_last_carrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[56:51] == LAST_CARRIER))
    else $error("tlast on a carrier other than 26");

  // A stalled read stage keeps its entry.
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !advance) |=> (rd_valid_q && $stable(rdata_q)))
    else $error("read stage lost its entry while stalled");

  // The emit phase starts only after a full symbol has been loaded.
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLoad && phase_d == PhEmit) |-> (load_cnt_d == '0 && pos_q == '0))
    else $error("emit phase entered mid-symbol");

endmodule
